// ===== sv/ffpt_pkg.sv =====
// Package for the fractional flow pulse totaliser.
// Holds widths, limits, register indexes and the item and result types.
// No dependencies.
`default_nettype none

package ffpt_pkg;

  // Running totals and interval timer widths
  localparam int unsigned TOTAL_WIDTH = 32;
  localparam int unsigned TIMER_WIDTH = 16;

  // Field widths of the configuration registers and internal counters
  localparam int unsigned RATIO_WIDTH = 16;
  localparam int unsigned LEN_WIDTH   = 8;
  localparam int unsigned VOL_WIDTH   = 5;
  localparam int unsigned KILO_WIDTH  = 7;
  localparam int unsigned OUT_WIDTH   = 32;
  localparam int unsigned IVL_WIDTH   = 16;

  // Mark limits: volume fires once the count passes VOLUME_LIMIT
  localparam logic [VOL_WIDTH-1:0]  VOLUME_LIMIT = VOL_WIDTH'(20);
  localparam logic [KILO_WIDTH-1:0] KILO_LIMIT   = KILO_WIDTH'(100);

  // Register reset values
  localparam logic [RATIO_WIDTH-1:0] RATIO_RESET = RATIO_WIDTH'(10);
  localparam logic [LEN_WIDTH-1:0]   LEN_RESET   = LEN_WIDTH'(1);

  // Configuration port
  localparam int unsigned CFG_IDX_WIDTH  = 3;
  localparam int unsigned CFG_DATA_WIDTH = 16;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_RATIO_A  = 3'd0,
    REG_RATIO_B  = 3'd1,
    REG_LEN_A    = 3'd2,
    REG_LEN_B    = 3'd3,
    REG_DISABLE  = 3'd4
  } cfg_reg_t;

  // Input item: tick or pulse
  typedef struct packed {
    logic action;          // 0 tick, 1 pulse edge
    logic filling_active;
  } item_t;

  // Result item
  typedef struct packed {
    logic [IVL_WIDTH-1:0] interval_ticks;
    logic                 unit_step;
    logic                 phase;
    logic [OUT_WIDTH-1:0] totalizer_a;
    logic [OUT_WIDTH-1:0] totalizer_b;
    logic [OUT_WIDTH-1:0] weight_units;
    logic                 volume_mark;
    logic                 kilo_mark;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/fractional_flow_pulse_totalizer_unit.sv =====
// Top level of the fractional flow pulse totaliser.
// Counter state, prescaler and result register; uses ffpt_pkg.
//
//  Channel  | Handshake                | Payload
//  ---------+--------------------------+------------------------------
//  item     | item_valid / item_stall   | item (item_t)
//  result   | result_valid / result_stall | result (result_t)
//  cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One item per cycle while item_stall is low; each accepted item gives one result in the next cycle.
// All counter updates happen in a single pass between the item port and the
// result register. item_stall rises only while a result sits unread under
// result_stall. cfg_ready is always high. rst is synchronous, active high.
`default_nettype none

module fractional_flow_pulse_totalizer_unit
  import ffpt_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      item_valid,
  output logic                           item_stall,
  input  wire item_t                     item,
  output logic                           result_valid,
  input  wire logic                      result_stall,
  output result_t                        result,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data
);

  // Configuration registers
  logic [RATIO_WIDTH-1:0] ratio_a;
  logic [RATIO_WIDTH-1:0] ratio_b;
  logic [LEN_WIDTH-1:0]   len_a;
  logic [LEN_WIDTH-1:0]   len_b;
  logic                   switch_disable;

  // Counter state
  logic                   ratio_phase, ratio_phase_next;
  logic [RATIO_WIDTH-1:0] pulse_count, pulse_count_next;
  logic [LEN_WIDTH-1:0]   unit_count, unit_count_next;
  logic [TIMER_WIDTH-1:0] tick_count, tick_count_next;
  logic [VOL_WIDTH-1:0]   small_volume_count, small_volume_count_next;
  logic [KILO_WIDTH-1:0]  kilo_count, kilo_count_next;
  logic [TOTAL_WIDTH-1:0] total_a, total_a_next;
  logic [TOTAL_WIDTH-1:0] total_b, total_b_next;
  logic [TOTAL_WIDTH-1:0] weight_count, weight_count_next;
  logic [IVL_WIDTH-1:0]   held_interval, held_interval_next;

  logic                   step, vmark, kmark;
  logic                   accept;
  logic [RATIO_WIDTH-1:0] ratio;
  logic [RATIO_WIDTH-1:0] pulse_inc;
  logic [LEN_WIDTH-1:0]   unit_inc;
  logic [VOL_WIDTH-1:0]   vol_inc;
  logic [KILO_WIDTH-1:0]  kilo_inc;
  logic [63:0]            tick_wide;
  logic [63:0]            ta_wide, tb_wide, wt_wide;

  // Handshake: stall only while an unread result is held
  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;
  assign cfg_ready  = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_a        <= RATIO_RESET;
      ratio_b        <= RATIO_RESET;
      len_a          <= LEN_RESET;
      len_b          <= LEN_RESET;
      switch_disable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RATIO_A: ratio_a        <= cfg_data[RATIO_WIDTH-1:0];
        REG_RATIO_B: ratio_b        <= cfg_data[RATIO_WIDTH-1:0];
        REG_LEN_A:   len_a          <= cfg_data[LEN_WIDTH-1:0];
        REG_LEN_B:   len_b          <= cfg_data[LEN_WIDTH-1:0];
        REG_DISABLE: switch_disable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign ratio     = ratio_phase ? ratio_b : ratio_a;
  assign pulse_inc = pulse_count + RATIO_WIDTH'(1);
  assign unit_inc  = unit_count + LEN_WIDTH'(1);
  assign vol_inc   = small_volume_count + VOL_WIDTH'(1);
  assign kilo_inc  = kilo_count + KILO_WIDTH'(1);
  assign tick_wide = 64'(tick_count);

  // Next state for one item
  always_comb begin
    ratio_phase_next        = ratio_phase;
    pulse_count_next        = pulse_count;
    unit_count_next         = unit_count;
    tick_count_next         = tick_count;
    small_volume_count_next = small_volume_count;
    kilo_count_next         = kilo_count;
    total_a_next            = total_a;
    total_b_next            = total_b;
    weight_count_next       = weight_count;
    held_interval_next      = held_interval;
    step  = 1'b0;
    vmark = 1'b0;
    kmark = 1'b0;

    if (!item.action) begin
      tick_count_next = tick_count + TIMER_WIDTH'(1);
    end else if (item.filling_active) begin
      held_interval_next = tick_wide[IVL_WIDTH-1:0];
      tick_count_next    = '0;
      pulse_count_next   = pulse_inc;
      if (pulse_inc == ratio) begin
        step                    = 1'b1;
        pulse_count_next        = '0;
        unit_count_next         = unit_inc;
        kilo_count_next         = kilo_inc;
        small_volume_count_next = vol_inc;
        total_a_next            = total_a + TOTAL_WIDTH'(1);
        total_b_next            = total_b + TOTAL_WIDTH'(1);
        weight_count_next       = weight_count + TOTAL_WIDTH'(1);
        // Phase change after the set number of units
        if (!ratio_phase) begin
          if (unit_inc == len_a && !switch_disable) begin
            ratio_phase_next = 1'b1;
            unit_count_next  = '0;
          end
        end else if (unit_inc == len_b) begin
          ratio_phase_next = 1'b0;
          unit_count_next  = '0;
        end
      end
      // Marks: volume every 21 units, kilo every 100
      if (small_volume_count_next > VOLUME_LIMIT) begin
        vmark                   = 1'b1;
        small_volume_count_next = '0;
      end
      if (kilo_count_next == KILO_LIMIT) begin
        kmark           = 1'b1;
        kilo_count_next = '0;
      end
    end
  end

  // Counter state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_phase        <= 1'b0;
      pulse_count        <= '0;
      unit_count         <= '0;
      tick_count         <= '0;
      small_volume_count <= '0;
      kilo_count         <= '0;
      total_a            <= '0;
      total_b            <= '0;
      weight_count       <= '0;
      held_interval      <= '0;
    end else if (accept) begin
      ratio_phase        <= ratio_phase_next;
      pulse_count        <= pulse_count_next;
      unit_count         <= unit_count_next;
      tick_count         <= tick_count_next;
      small_volume_count <= small_volume_count_next;
      kilo_count         <= kilo_count_next;
      total_a            <= total_a_next;
      total_b            <= total_b_next;
      weight_count       <= weight_count_next;
      held_interval      <= held_interval_next;
    end
  end

  assign ta_wide = 64'(total_a_next);
  assign tb_wide = 64'(total_b_next);
  assign wt_wide = 64'(weight_count_next);

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Result payload, loaded on each item transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      result.interval_ticks <= held_interval_next;
      result.unit_step      <= step;
      result.phase          <= ratio_phase_next;
      result.totalizer_a    <= ta_wide[OUT_WIDTH-1:0];
      result.totalizer_b    <= tb_wide[OUT_WIDTH-1:0];
      result.weight_units   <= wt_wide[OUT_WIDTH-1:0];
      result.volume_mark    <= vmark;
      result.kilo_mark      <= kmark;
    end
  end

endmodule

`default_nettype wire

// ===== tb/fractional_flow_pulse_totalizer_unit_tb.sv =====
// Self-checking bench for fractional_flow_pulse_totalizer_unit: ticks and flow pulses go in,
// each result transfer is checked against a behavioural model of the totaliser kept here.
// Depends on ffpt_pkg and the unit itself.

module fractional_flow_pulse_totalizer_unit_tb;
  import ffpt_pkg::*;

  localparam int RUN_LIMIT     = 40_000_000;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int SETTLE        = 2;
  localparam int RANDOM_ITEMS  = 850;
  localparam int PHASE_ITEMS   = 120;
  localparam int MAX_REPORTS   = 200;
  localparam int DIRECTED_ROWS = 17;

  // Item kinds
  localparam item_t TICK_IDLE  = '{action: 1'b0, filling_active: 1'b0};
  localparam item_t TICK_FILL  = '{action: 1'b0, filling_active: 1'b1};
  localparam item_t PULSE_IDLE = '{action: 1'b1, filling_active: 1'b0};
  localparam item_t PULSE_FILL = '{action: 1'b1, filling_active: 1'b1};

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t want;
  } stim_row_t;

  typedef enum int {PACE_GAPS, PACE_SPARSE, PACE_FLAT} pace_t;

  // Directed table, run with ratios 1/2 and phase lengths 2/1.
  // Typed results: interval, unit_step, phase, tot_a, tot_b, weight, 200 g mark, 1 kg mark
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{TICK_IDLE,  1'b1, '{16'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
    '{TICK_FILL,  1'b1, '{16'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
    '{PULSE_IDLE, 1'b1, '{16'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
    '{PULSE_FILL, 1'b1, '{16'd2, 1'b1, 1'b0, 32'd1, 32'd1, 32'd1, 1'b0, 1'b0}},
    '{PULSE_FILL, 1'b1, '{16'd0, 1'b1, 1'b1, 32'd2, 32'd2, 32'd2, 1'b0, 1'b0}},
    '{PULSE_FILL, 1'b1, '{16'd0, 1'b0, 1'b1, 32'd2, 32'd2, 32'd2, 1'b0, 1'b0}},
    '{PULSE_IDLE, 1'b1, '{16'd0, 1'b0, 1'b1, 32'd2, 32'd2, 32'd2, 1'b0, 1'b0}},
    '{TICK_IDLE,  1'b1, '{16'd0, 1'b0, 1'b1, 32'd2, 32'd2, 32'd2, 1'b0, 1'b0}},
    '{PULSE_FILL, 1'b1, '{16'd1, 1'b1, 1'b0, 32'd3, 32'd3, 32'd3, 1'b0, 1'b0}},
    '{TICK_FILL,  1'b0, '0},
    '{TICK_IDLE,  1'b0, '0},
    '{PULSE_FILL, 1'b0, '0},
    '{PULSE_FILL, 1'b0, '0},
    '{TICK_FILL,  1'b0, '0},
    '{PULSE_IDLE, 1'b0, '0},
    '{PULSE_FILL, 1'b0, '0},
    '{PULSE_FILL, 1'b0, '0}
  };

  logic                      clk;
  logic                      rst;
  logic                      item_valid;
  logic                      item_stall;
  item_t                     item;
  logic                      result_valid;
  logic                      result_stall;
  result_t                   result;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_WIDTH-1:0]  cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_data;

  // Typed expectation travelling alongside the item payload
  logic    row_typed;
  result_t row_want;

  pace_t pace = PACE_GAPS;

  // Model copy of the registers
  logic [RATIO_WIDTH-1:0] ratio_a     = RATIO_RESET;
  logic [RATIO_WIDTH-1:0] ratio_b     = RATIO_RESET;
  logic [LEN_WIDTH-1:0]   len_a       = LEN_RESET;
  logic [LEN_WIDTH-1:0]   len_b       = LEN_RESET;
  logic                   stay_in_one = 1'b0;

  // Model copy of the counter state
  logic                   cur_phase     = 1'b0;
  logic [RATIO_WIDTH-1:0] pulse_tally   = '0;
  logic [LEN_WIDTH-1:0]   unit_tally    = '0;
  logic [TIMER_WIDTH-1:0] tick_tally    = '0;
  logic [VOL_WIDTH-1:0]   vol_tally     = '0;
  logic [KILO_WIDTH-1:0]  kg_tally      = '0;
  logic [TOTAL_WIDTH-1:0] sum_a         = '0;
  logic [TOTAL_WIDTH-1:0] sum_b         = '0;
  logic [TOTAL_WIDTH-1:0] weight_sum    = '0;
  logic [IVL_WIDTH-1:0]   held_interval = '0;

  result_t pending_readings [$];

  int mismatches   = 0;
  int items_seen   = 0;
  int results_seen = 0;
  int writes_seen  = 0;
  int units_seen   = 0;
  int vol_marks    = 0;
  int kg_marks     = 0;

  fractional_flow_pulse_totalizer_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Run limit reached with %0d results outstanding", pending_readings.size());
    $display("** fractional_flow_pulse_totalizer_unit: FAILED **");
    $finish;
  end

  // Idle length for either side: gap pace mostly none, some short, a few long; sparse rarely short; flat none
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    case (pace)
      PACE_FLAT:   return 0;
      PACE_SPARSE: return (r < 10) ? 1 : 0;
      default: begin
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
      end
    endcase
  endfunction

  // Prescaler, phase sequencer and totalisers for one accepted item
  function automatic result_t advance_totalizer(input item_t it);
    result_t                r;
    logic [RATIO_WIDTH-1:0] ratio;
    r = '0;
    if (!it.action) begin
      tick_tally = tick_tally + TIMER_WIDTH'(1);
    end else if (it.filling_active) begin
      ratio         = cur_phase ? ratio_b : ratio_a;
      held_interval = IVL_WIDTH'(tick_tally);
      tick_tally    = '0;
      pulse_tally   = pulse_tally + RATIO_WIDTH'(1);
      if (pulse_tally == ratio) begin
        r.unit_step = 1'b1;
        pulse_tally = '0;
        unit_tally  = unit_tally + LEN_WIDTH'(1);
        kg_tally    = kg_tally + KILO_WIDTH'(1);
        vol_tally   = vol_tally + VOL_WIDTH'(1);
        sum_a       = sum_a + TOTAL_WIDTH'(1);
        sum_b       = sum_b + TOTAL_WIDTH'(1);
        weight_sum  = weight_sum + TOTAL_WIDTH'(1);
        // phase one only leaves when switching is allowed
        if (!cur_phase) begin
          if (unit_tally == len_a && !stay_in_one) begin
            cur_phase  = 1'b1;
            unit_tally = '0;
          end
        end else if (unit_tally == len_b) begin
          cur_phase  = 1'b0;
          unit_tally = '0;
        end
      end
      if (vol_tally > VOLUME_LIMIT) begin
        r.volume_mark = 1'b1;
        vol_tally     = '0;
      end
      if (kg_tally == KILO_LIMIT) begin
        r.kilo_mark = 1'b1;
        kg_tally    = '0;
      end
    end
    r.interval_ticks = held_interval;
    r.phase          = cur_phase;
    r.totalizer_a    = OUT_WIDTH'(sum_a);
    r.totalizer_b    = OUT_WIDTH'(sum_b);
    r.weight_units   = OUT_WIDTH'(weight_sum);
    return r;
  endfunction

  task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      // print is capped so a dead block cannot flood the log
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Scoreboard: results against oldest expectation, then register writes and new items
  always @(posedge clk) begin : score
    result_t due;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (pending_readings.size() == 0) begin
          $display("%0t: result transfer with nothing expected, got %h", $time, result);
          mismatches++;
        end else begin
          due = pending_readings.pop_front();
          flag_field("interval_ticks", 32'(due.interval_ticks), 32'(result.interval_ticks));
          flag_field("unit_step", 32'(due.unit_step), 32'(result.unit_step));
          flag_field("phase", 32'(due.phase), 32'(result.phase));
          flag_field("totalizer_a", due.totalizer_a, result.totalizer_a);
          flag_field("totalizer_b", due.totalizer_b, result.totalizer_b);
          flag_field("weight_units", due.weight_units, result.weight_units);
          flag_field("volume_mark", 32'(due.volume_mark), 32'(result.volume_mark));
          flag_field("kilo_mark", 32'(due.kilo_mark), 32'(result.kilo_mark));
          units_seen += due.unit_step;
          vol_marks  += due.volume_mark;
          kg_marks   += due.kilo_mark;
        end
      end
      if (cfg_valid && cfg_ready) begin
        writes_seen++;
        case (cfg_reg_t'(cfg_index))
          REG_RATIO_A: ratio_a     = cfg_data[RATIO_WIDTH-1:0];
          REG_RATIO_B: ratio_b     = cfg_data[RATIO_WIDTH-1:0];
          REG_LEN_A:   len_a       = cfg_data[LEN_WIDTH-1:0];
          REG_LEN_B:   len_b       = cfg_data[LEN_WIDTH-1:0];
          REG_DISABLE: stay_in_one = cfg_data[0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        items_seen++;
        due = advance_totalizer(item);
        if (row_typed) due = row_want;
        pending_readings.push_back(due);
      end
    end
  end

  // Receiver back-pressure; result_stall always drops between two stall bursts
  initial begin : result_pacer
    int remain;
    remain       = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (remain > 0) begin
        result_stall <= 1'b1;
        remain--;
      end else begin
        result_stall <= 1'b0;
        remain = pick_gap();
      end
    end
  end

  task automatic send_item(input item_t it, input logic typed, input result_t want);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    row_typed  <= typed;
    row_want   <= want;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic send_burst(input item_t it, input int count);
    repeat (count) send_item(it, 1'b0, '0);
  endtask

  // Hold the sender until every expected result is back or DRAIN_LIMIT runs out, then let the block settle
  task automatic drain(input int settle);
    int waited;
    waited = 0;
    @(negedge clk);
    item_valid <= 1'b0;
    row_typed  <= 1'b0;
    while (pending_readings.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending_readings.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_readings.size());
      mismatches += pending_readings.size();
      pending_readings.delete();
    end
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_WIDTH'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int    ra, rb, la, lb, dis;
    int    counted, in_phase, ph, pick;
    item_t it;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    row_typed  = 1'b0;
    row_want   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_RATIO_A;
    cfg_data   = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed table
    write_reg(REG_RATIO_A, 1);
    write_reg(REG_RATIO_B, 2);
    write_reg(REG_LEN_A, 2);
    write_reg(REG_LEN_B, 1);
    write_reg(REG_DISABLE, 0);
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_item(DIRECTED[i].it, DIRECTED[i].typed, DIRECTED[i].want);

    // Get into phase two, then set the disable: phase two must still return
    pace = PACE_SPARSE;
    drain(SETTLE);
    write_reg(REG_RATIO_A, 1);
    write_reg(REG_RATIO_B, 1);
    write_reg(REG_LEN_A, 1);
    write_reg(REG_LEN_B, 3);
    write_reg(REG_DISABLE, 0);
    do begin
      send_burst(PULSE_FILL, 1);
      drain(SETTLE);
    end while (!cur_phase);
    write_reg(REG_DISABLE, 1);
    // phase one held: unit count runs past 255 and wraps
    send_burst(PULSE_FILL, 300);
    drain(SETTLE);
    // phase length now below the unit count: switch waits for the wrap
    write_reg(REG_LEN_A, 2);
    write_reg(REG_DISABLE, 0);
    send_burst(PULSE_FILL, 300);

    // Random phases, each with its own register setting
    counted = 0;
    ph      = 0;
    while (counted < RANDOM_ITEMS) begin
      drain(SETTLE);
      pick = $urandom_range(99);
      pace = (pick < 70) ? PACE_GAPS : (pick < 85) ? PACE_SPARSE : PACE_FLAT;
      if (ph == 0) begin
        ra = 1; rb = 1; la = 1; lb = 1; dis = 0;
      end else if (ph == 1) begin
        ra = 65535; rb = 65535; la = 255; lb = 255; dis = 1;
      end else begin
        ra  = ($urandom_range(4) != 0) ? $urandom_range(6, 1) : $urandom_range(65535, 1);
        rb  = ($urandom_range(4) != 0) ? $urandom_range(6, 1) : $urandom_range(65535, 1);
        la  = ($urandom_range(4) != 0) ? $urandom_range(8, 1) : $urandom_range(255, 1);
        lb  = ($urandom_range(4) != 0) ? $urandom_range(8, 1) : $urandom_range(255, 1);
        dis = ($urandom_range(3) == 0);
      end
      // keep the live ratio and length above the running counts so nothing wraps here
      if (cur_phase) begin
        if (rb <= int'(pulse_tally)) rb = int'(pulse_tally) + $urandom_range(5, 1);
        if (lb <= int'(unit_tally)) lb = int'(unit_tally) + 1;
      end else begin
        if (ra <= int'(pulse_tally)) ra = int'(pulse_tally) + $urandom_range(5, 1);
        if (la <= int'(unit_tally)) la = int'(unit_tally) + 1;
      end
      if (ra > 65535) ra = 65535;
      if (rb > 65535) rb = 65535;
      if (la > 255) la = 255;
      if (lb > 255) lb = 255;
      write_reg(REG_RATIO_A, ra);
      write_reg(REG_RATIO_B, rb);
      write_reg(REG_LEN_A, la);
      write_reg(REG_LEN_B, lb);
      write_reg(REG_DISABLE, dis);

      in_phase = 0;
      while (in_phase < PHASE_ITEMS && counted < RANDOM_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 62) it = PULSE_FILL;
        else if (pick < 90) it = ($urandom_range(1) != 0) ? TICK_FILL : TICK_IDLE;
        else it = PULSE_IDLE;
        send_item(it, 1'b0, '0);
        if (it != PULSE_IDLE) begin
          in_phase++;
          counted++;
        end
      end
      ph++;
    end

    drain(4);
    $display("Run: %0d items in, %0d results checked, %0d register writes, %0d phases.",
             items_seen, results_seen, writes_seen, ph);
    $display("Units %0d, 200 g marks %0d, 1 kg marks %0d; unit count wrap included.",
             units_seen, vol_marks, kg_marks);
    if (mismatches == 0) begin
      $display("** fractional_flow_pulse_totalizer_unit: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** fractional_flow_pulse_totalizer_unit: FAILED **");
    end
    $finish;
  end

endmodule
